### hw/rtl/lpls_pkg.sv
// lpls_pkg: shared constants for the laser point list scanner
// field widths, item mode codes and the default point buffer depth
// no dependencies
package lpls_pkg;

   localparam int MAX_POINTS_DEF = 2048;

   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 11;
   localparam int COORD_W  = 12;
   localparam int LEVEL_W  = 8;
   localparam int SIZE_W   = 12;
   localparam int COLOUR_W = 3 * LEVEL_W;
   localparam int POINT_W  = 2 * COORD_W + COLOUR_W;

   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd2;

   // remainder unit retires one dividend bit per cycle
   localparam int DIV_STEPS = SIZE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

### hw/rtl/laser_point_list_scanner_unit.sv
// laser_point_list_scanner_unit: double buffered point list scanner for a galvo display
// holds the two point buffers in one memory and a small sequencer with a bit serial remainder unit
// depends on lpls_pkg
//
// usage
//   req channel: one beat per item; mode picks tick (draw one point), load (write a point into
//   the hidden buffer at point_index) or commit (frame_size becomes pending, swap on next tick)
//   rsp channel: exactly one beat per req beat, in order; load, commit and unused modes answer
//   with all fields zero
//   sequencing: load and commit pass decode and finish; a tick passes decode, read, draw and
//   finish (read then finish when the frame is empty); a tick that swaps onto a nonzero size
//   with a nonzero read position first runs the bit serial remainder of the read position by
//   the new size; one item in flight; req_stall is high from the req beat until the result is
//   moved into the rsp register, so the item rate is set by the remainder unit and the
//   registered point memory read
//   rsp_stall: the rsp register holds its beat; the next item may be taken meanwhile but waits
//   in its last step until the rsp register frees
//   reset: buffers select 0, empty frame, no pending swap, last colour black; the point memory
//   is not cleared and must be loaded before it is drawn
module laser_point_list_scanner_unit #(
   parameter int MAX_POINTS = lpls_pkg::MAX_POINTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lpls_pkg::MODE_W-1:0]  req_mode,
   input  logic [lpls_pkg::INDEX_W-1:0] req_point_index,
   input  logic [lpls_pkg::COORD_W-1:0] req_x_coord,
   input  logic [lpls_pkg::COORD_W-1:0] req_y_coord,
   input  logic [lpls_pkg::LEVEL_W-1:0] req_red_level,
   input  logic [lpls_pkg::LEVEL_W-1:0] req_green_level,
   input  logic [lpls_pkg::LEVEL_W-1:0] req_blue_level,
   input  logic [lpls_pkg::SIZE_W-1:0]  req_frame_size,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_draw_valid,
   output logic [lpls_pkg::COORD_W-1:0] rsp_out_x,
   output logic [lpls_pkg::COORD_W-1:0] rsp_out_y,
   output logic [lpls_pkg::LEVEL_W-1:0] rsp_out_red,
   output logic [lpls_pkg::LEVEL_W-1:0] rsp_out_green,
   output logic [lpls_pkg::LEVEL_W-1:0] rsp_out_blue,
   output logic                         rsp_colour_changed,
   output logic                         rsp_swapped_unblank
);

   localparam int Depth = 2 * MAX_POINTS;
   localparam int AddrW = $clog2(Depth);
   localparam int SizeW = lpls_pkg::SIZE_W;
   localparam int PointW = lpls_pkg::POINT_W;
   localparam int ColourW = lpls_pkg::COLOUR_W;
   localparam int LevelW = lpls_pkg::LEVEL_W;
   localparam int CoordW = lpls_pkg::COORD_W;
   localparam int CntW = lpls_pkg::DIV_CNT_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_DIV    = 6'b000100,
      S_READ   = 6'b001000,
      S_DRAW   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [lpls_pkg::MODE_W-1:0]  mode_ff;
   logic [lpls_pkg::INDEX_W-1:0] index_ff;
   logic [PointW-1:0]            point_ff;
   logic [SizeW-1:0]             size_ff;

   // scanner state
   logic             front_ff, front_in;
   logic [SizeW-1:0] pos_ff, pos_in;
   logic [SizeW-1:0] shown_ff, shown_in;
   logic [SizeW-1:0] pending_ff, pending_in;
   logic             swap_pend_ff, swap_pend_in;
   logic [ColourW-1:0] last_colour_ff, last_colour_in;

   // remainder unit
   logic [SizeW-1:0] dvd_ff, dvd_in;
   logic [SizeW-1:0] rem_ff, rem_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [SizeW:0]   trial;
   logic [SizeW:0]   trial_diff;

   // result staging
   logic res_draw_ff, res_draw_in;
   logic res_changed_ff, res_changed_in;
   logic res_swap_ff, res_swap_in;

   // point memory, bank 0 then bank 1
   logic [PointW-1:0] mem [Depth];
   logic [PointW-1:0] rd_data_ff;
   logic              mem_we;
   logic [AddrW-1:0]  wr_addr;
   logic              mem_re;
   logic [AddrW-1:0]  rd_addr;

   logic rsp_valid_ff;
   logic rsp_draw_ff, rsp_changed_ff, rsp_swap_ff;
   logic [PointW-1:0] rsp_point_ff;
   logic rsp_free;
   logic rsp_load;

   logic [SizeW-1:0] size_sat;
   logic [SizeW:0]   pos_next;
   logic             can_draw;
   logic             req_take;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == S_FINISH) && rsp_free;

   assign size_sat = (32'(size_ff) > MAX_POINTS) ? SizeW'(MAX_POINTS) : size_ff;

   assign trial = {rem_ff, dvd_ff[SizeW-1]};
   assign trial_diff = trial - {1'b0, shown_ff};

   assign pos_next = {1'b0, pos_ff} + {{SizeW{1'b0}}, 1'b1};
   assign can_draw = (shown_ff != '0) && (pos_ff < shown_ff) && (32'(pos_ff) < MAX_POINTS);

   assign wr_addr = front_ff ? AddrW'(index_ff) : AddrW'(MAX_POINTS) + AddrW'(index_ff);
   assign rd_addr = front_ff ? AddrW'(MAX_POINTS) + AddrW'(pos_ff) : AddrW'(pos_ff);
   assign mem_we = (state_ff == S_DECODE) && (mode_ff == lpls_pkg::MODE_LOAD) &&
                   (32'(index_ff) < MAX_POINTS);
   assign mem_re = (state_ff == S_READ) && can_draw;

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      pos_in         = pos_ff;
      shown_in       = shown_ff;
      pending_in     = pending_ff;
      swap_pend_in   = swap_pend_ff;
      last_colour_in = last_colour_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      res_draw_in    = res_draw_ff;
      res_changed_in = res_changed_ff;
      res_swap_in    = res_swap_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_draw_in    = 1'b0;
            res_changed_in = 1'b0;
            res_swap_in    = 1'b0;
            state_in       = S_FINISH;
            case (mode_ff)
               lpls_pkg::MODE_COMMIT: begin
                  pending_in   = size_sat;
                  swap_pend_in = 1'b1;
               end
               lpls_pkg::MODE_TICK: begin
                  state_in = S_READ;
                  if (swap_pend_ff) begin
                     // hidden bank is the one that was !front_ff, written via wr_addr
                     front_in     = !front_ff;
                     shown_in     = pending_ff;
                     swap_pend_in = 1'b0;
                     res_swap_in  = 1'b1;
                     if (pending_ff != '0 && pos_ff != '0) begin
                        dvd_in   = pos_ff;
                        rem_in   = '0;
                        cnt_in   = '0;
                        state_in = S_DIV;
                     end else begin
                        pos_in = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            // restoring remainder, one dividend bit per cycle
            dvd_in = {dvd_ff[SizeW-2:0], 1'b0};
            if (!trial_diff[SizeW]) begin
               rem_in = trial_diff[SizeW-1:0];
            end else begin
               rem_in = trial[SizeW-1:0];
            end
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(lpls_pkg::DIV_STEPS - 1)) begin
               pos_in   = rem_in;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = can_draw ? S_DRAW : S_FINISH;
         end
         S_DRAW: begin
            res_draw_in    = 1'b1;
            res_changed_in = (rd_data_ff[ColourW-1:0] != last_colour_ff);
            last_colour_in = rd_data_ff[ColourW-1:0];
            pos_in         = (pos_next >= {1'b0, shown_ff}) ? '0 : pos_next[SizeW-1:0];
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         front_ff       <= 1'b0;
         pos_ff         <= '0;
         shown_ff       <= '0;
         pending_ff     <= '0;
         swap_pend_ff   <= 1'b0;
         last_colour_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         front_ff       <= front_in;
         pos_ff         <= pos_in;
         shown_ff       <= shown_in;
         pending_ff     <= pending_in;
         swap_pend_ff   <= swap_pend_in;
         last_colour_ff <= last_colour_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      res_draw_ff    <= res_draw_in;
      res_changed_ff <= res_changed_in;
      res_swap_ff    <= res_swap_in;
      if (req_take) begin
         mode_ff  <= req_mode;
         index_ff <= req_point_index;
         point_ff <= {req_x_coord, req_y_coord, req_red_level, req_green_level,
                      req_blue_level};
         size_ff  <= req_frame_size;
      end
      if (rsp_load) begin
         rsp_draw_ff    <= res_draw_ff;
         rsp_changed_ff <= res_changed_ff;
         rsp_swap_ff    <= res_swap_ff;
         rsp_point_ff   <= res_draw_ff ? rd_data_ff : '0;
      end
   end

   // loads go to the hidden bank
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= point_ff;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_draw_valid      = rsp_draw_ff;
   assign rsp_out_x           = rsp_point_ff[PointW-1 -: CoordW];
   assign rsp_out_y           = rsp_point_ff[PointW-CoordW-1 -: CoordW];
   assign rsp_out_red         = rsp_point_ff[3*LevelW-1 -: LevelW];
   assign rsp_out_green       = rsp_point_ff[2*LevelW-1 -: LevelW];
   assign rsp_out_blue        = rsp_point_ff[LevelW-1:0];
   assign rsp_colour_changed  = rsp_changed_ff;
   assign rsp_swapped_unblank = rsp_swap_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_size_bounded: assert property (@(posedge clock) disable iff (reset)
      (32'(shown_ff) <= MAX_POINTS) && (32'(pending_ff) <= MAX_POINTS))
      else $error("frame size above buffer depth");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((shown_ff == '0) ? (pos_ff == '0) : (pos_ff < shown_ff)))
      else $error("read position outside frame");

   a_draw_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAW) |-> ($past(state_ff) == S_READ) && (shown_ff != '0))
      else $error("point drawn from empty frame");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (32'(cnt_ff) < lpls_pkg::DIV_STEPS))
      else $error("remainder unit overran its step count");
`endif

endmodule

### sim/laser_point_list_scanner_unit_tb.sv
// laser_point_list_scanner_unit_tb: self-checking testbench for the point list scanner
// keeps its own model of both point buffers and the swap logic, and checks every rsp beat
// depends on lpls_pkg and laser_point_list_scanner_unit
module laser_point_list_scanner_unit_tb;

   localparam int NPTS = lpls_pkg::MAX_POINTS_DEF;
   localparam int SIZE_MAX = (1 << lpls_pkg::SIZE_W) - 1;
   localparam logic [lpls_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_OFF_LEN = 400;
   localparam int BIG_HEAD = 64;
   localparam int PHASE_ITEMS = 420;

   typedef struct packed {
      logic                          draw_valid;
      logic [lpls_pkg::COORD_W-1:0]  x;
      logic [lpls_pkg::COORD_W-1:0]  y;
      logic [lpls_pkg::LEVEL_W-1:0]  red;
      logic [lpls_pkg::LEVEL_W-1:0]  green;
      logic [lpls_pkg::LEVEL_W-1:0]  blue;
      logic                          colour_changed;
      logic                          swapped_unblank;
   } scan_out_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [lpls_pkg::MODE_W-1:0]   req_mode;
   logic [lpls_pkg::INDEX_W-1:0]  req_point_index;
   logic [lpls_pkg::COORD_W-1:0]  req_x_coord;
   logic [lpls_pkg::COORD_W-1:0]  req_y_coord;
   logic [lpls_pkg::LEVEL_W-1:0]  req_red_level;
   logic [lpls_pkg::LEVEL_W-1:0]  req_green_level;
   logic [lpls_pkg::LEVEL_W-1:0]  req_blue_level;
   logic [lpls_pkg::SIZE_W-1:0]   req_frame_size;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_draw_valid;
   logic [lpls_pkg::COORD_W-1:0]  rsp_out_x;
   logic [lpls_pkg::COORD_W-1:0]  rsp_out_y;
   logic [lpls_pkg::LEVEL_W-1:0]  rsp_out_red;
   logic [lpls_pkg::LEVEL_W-1:0]  rsp_out_green;
   logic [lpls_pkg::LEVEL_W-1:0]  rsp_out_blue;
   logic                          rsp_colour_changed;
   logic                          rsp_swapped_unblank;

   // scanner model: point buffers, loaded flags and sequencing state
   logic [lpls_pkg::POINT_W-1:0]  point_mem [0:2*NPTS-1];
   bit                            point_loaded [0:2*NPTS-1];
   bit                            front_sel = 1'b0;
   logic [lpls_pkg::INDEX_W-1:0]  read_pos = '0;
   logic [lpls_pkg::SIZE_W-1:0]   shown_size = '0;
   logic [lpls_pkg::SIZE_W-1:0]   pending_size = '0;
   bit                            swap_due = 1'b0;
   logic [lpls_pkg::COLOUR_W-1:0] last_colour = '0;

   scan_out_type        expected_beats [$];
   int unsigned         idle_pct = 0;
   int unsigned         stall_pct = 0;
   int                  hold_off_cycles = 0;
   int                  items_sent = 0;
   int                  cycle_count = 0;
   int                  errors = 0;
   int                  n_draws = 0;
   int                  n_swaps = 0;
   int                  n_colour_changes = 0;

   laser_point_list_scanner_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_point_index     (req_point_index),
      .req_x_coord         (req_x_coord),
      .req_y_coord         (req_y_coord),
      .req_red_level       (req_red_level),
      .req_green_level     (req_green_level),
      .req_blue_level      (req_blue_level),
      .req_frame_size      (req_frame_size),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_draw_valid      (rsp_draw_valid),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_red         (rsp_out_red),
      .rsp_out_green       (rsp_out_green),
      .rsp_out_blue        (rsp_out_blue),
      .rsp_colour_changed  (rsp_colour_changed),
      .rsp_swapped_unblank (rsp_swapped_unblank)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic scan_out_type scan_predict(input logic [lpls_pkg::MODE_W-1:0] mode,
         input logic [lpls_pkg::INDEX_W-1:0] idx, input logic [lpls_pkg::POINT_W-1:0] pt,
         input logic [lpls_pkg::SIZE_W-1:0] size);
      scan_out_type                 res;
      logic [lpls_pkg::POINT_W-1:0] cur;
      res = '0;
      case (mode)
         lpls_pkg::MODE_LOAD: begin
            point_mem[{~front_sel, idx}] = pt;
            point_loaded[{~front_sel, idx}] = 1'b1;
         end
         lpls_pkg::MODE_COMMIT: begin
            pending_size = (size > NPTS) ? lpls_pkg::SIZE_W'(NPTS) : size;
            swap_due = 1'b1;
         end
         lpls_pkg::MODE_TICK: begin
            if (swap_due) begin
               if (pending_size != 0 && read_pos != 0)
                  read_pos = lpls_pkg::INDEX_W'(read_pos % pending_size);
               else
                  read_pos = '0;
               shown_size = pending_size;
               front_sel = ~front_sel;
               swap_due = 1'b0;
               res.swapped_unblank = 1'b1;
            end
            if (shown_size != 0) begin
               cur = point_mem[{front_sel, read_pos}];
               res.draw_valid = 1'b1;
               {res.x, res.y, res.red, res.green, res.blue} = cur;
               res.colour_changed = (cur[lpls_pkg::COLOUR_W-1:0] != last_colour);
               last_colour = cur[lpls_pkg::COLOUR_W-1:0];
               if ({1'b0, read_pos} + 1 >= shown_size)
                  read_pos = '0;
               else
                  read_pos = read_pos + 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // longest run of loaded slots from slot zero in the hidden buffer
   function automatic int hidden_prefix();
      int n = 0;
      while (n < NPTS && point_loaded[{~front_sel, lpls_pkg::INDEX_W'(n)}])
         n++;
      return n;
   endfunction

   function automatic logic [lpls_pkg::POINT_W-1:0] rand_point();
      logic [lpls_pkg::COLOUR_W-1:0] col;
      // a few fixed colours so that repeats happen often
      case ($urandom_range(5))
         0: col = '0;
         1: col = '1;
         2: col = 24'h3c80ff;
         default: col = lpls_pkg::COLOUR_W'($urandom);
      endcase
      return {lpls_pkg::COORD_W'($urandom), lpls_pkg::COORD_W'($urandom), col};
   endfunction

   task automatic send_item(input logic [lpls_pkg::MODE_W-1:0] mode,
         input logic [lpls_pkg::INDEX_W-1:0] idx, input logic [lpls_pkg::POINT_W-1:0] pt,
         input logic [lpls_pkg::SIZE_W-1:0] size);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_point_index <= idx;
      {req_x_coord, req_y_coord, req_red_level, req_green_level, req_blue_level} <= pt;
      req_frame_size <= size;
      do @(posedge clock); while (req_stall);
      expected_beats.push_back(scan_predict(mode, idx, pt, size));
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(lpls_pkg::MODE_TICK, lpls_pkg::INDEX_W'($urandom), rand_point(),
                lpls_pkg::SIZE_W'($urandom));
   endtask

   task automatic send_load(input logic [lpls_pkg::INDEX_W-1:0] idx,
         input logic [lpls_pkg::POINT_W-1:0] pt);
      send_item(lpls_pkg::MODE_LOAD, idx, pt, lpls_pkg::SIZE_W'($urandom));
   endtask

   task automatic send_commit(input logic [lpls_pkg::SIZE_W-1:0] size);
      send_item(lpls_pkg::MODE_COMMIT, lpls_pkg::INDEX_W'($urandom), rand_point(), size);
   endtask

   task automatic wait_drained();
      if (req_valid)
         req_valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
   endtask

   // load a frame into the hidden buffer, commit it and draw it for a while;
   // commits never exceed the loaded prefix once clipped to the buffer depth, so no unwritten slot is drawn
   task automatic run_frame();
      int                          size;
      int                          pre;
      int                          n_ticks;
      logic [lpls_pkg::SIZE_W-1:0] commit_sz;
      case ($urandom_range(19))
         0: size = 0;
         1, 2: size = $urandom_range(9, 48);
         default: size = $urandom_range(1, 8);
      endcase
      pre = hidden_prefix();
      if (size <= pre && pre != 0 && $urandom_range(2) == 0) begin
         repeat ($urandom_range(0, 3))
            send_load(lpls_pkg::INDEX_W'($urandom_range(0, pre - 1)), rand_point());
      end else begin
         for (int i = 0; i < size; i++) begin
            if ($urandom_range(9) == 0)
               send_tick();
            send_load(lpls_pkg::INDEX_W'(i), rand_point());
         end
      end
      pre = hidden_prefix();
      if ($urandom_range(4) == 0)
         send_commit(lpls_pkg::SIZE_W'($urandom_range(0, pre)));
      if (pre == NPTS && $urandom_range(7) == 0)
         commit_sz = lpls_pkg::SIZE_W'($urandom_range(NPTS, SIZE_MAX));
      else if ($urandom_range(9) == 0)
         commit_sz = lpls_pkg::SIZE_W'($urandom_range(size, pre));
      else
         commit_sz = lpls_pkg::SIZE_W'(size);
      send_commit(commit_sz);
      n_ticks = $urandom_range(1, (size < 20) ? 2 * size + 3 : 60);
      repeat (n_ticks)
         send_tick();
   endtask

   task automatic run_noise();
      case ($urandom_range(4))
         0: send_item(MODE_UNUSED, lpls_pkg::INDEX_W'($urandom),
                      lpls_pkg::POINT_W'({$urandom, $urandom}), lpls_pkg::SIZE_W'($urandom));
         1: send_load(lpls_pkg::INDEX_W'($urandom), rand_point());
         2: send_commit('0);
         3: send_commit(lpls_pkg::SIZE_W'($urandom_range(0, hidden_prefix())));
         default: send_tick();
      endcase
   endtask

   task automatic test_directed();
      idle_pct = 0;
      stall_pct = 0;
      send_tick();
      send_item(MODE_UNUSED, '1, '1, '1);
      send_load(11'd0, '0);
      send_load(11'd1, '1);
      send_load(11'd2, {12'd0, 12'hfff, 24'hffffff});
      send_load(11'd3, rand_point());
      send_load('1, '1);
      // two commits before a tick: the second size counts, one swap
      send_commit('0);
      send_commit(12'd4);
      repeat (7)
         send_tick();
      send_item(MODE_UNUSED, '0, '0, '0);
      send_load(11'd0, rand_point());
      send_load(11'd1, rand_point());
      // read position 3 folds to 1 in a two point frame
      send_commit(12'd2);
      send_tick();
      send_commit('0);
      send_tick();
      send_tick();
      wait_drained();
   endtask

   task automatic test_full_frame();
      idle_pct = 0;
      stall_pct = 10;
      // empty the shown frame so drawing restarts at slot zero
      send_commit('0);
      send_tick();
      for (int i = 0; i < BIG_HEAD; i++)
         send_load(lpls_pkg::INDEX_W'(i), rand_point());
      // oversized frame clips to the buffer depth; only the loaded head is drawn
      send_commit(lpls_pkg::SIZE_W'($urandom_range(NPTS + 1, SIZE_MAX)));
      repeat (BIG_HEAD)
         send_tick();
      // leave an empty frame so later ticks never reach unloaded slots
      send_commit('0);
      send_tick();
      wait_drained();
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (3)
         run_frame();
      wait_drained();
      repeat (5)
         run_frame();
      wait_drained();
   endtask

   task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
         input int n);
      int first;
      idle_pct = idle;
      stall_pct = stall;
      first = items_sent;
      while (items_sent - first < n) begin
         if ($urandom_range(4) == 0)
            run_noise();
         else
            run_frame();
      end
      wait_drained();
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      scan_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: rsp beat with nothing expected, x %0h y %0h", $time,
                     rsp_out_x, rsp_out_y);
            errors++;
         end else begin
            want = expected_beats.pop_front();
            check_field("draw_valid", want.draw_valid, rsp_draw_valid);
            check_field("out_x", want.x, rsp_out_x);
            check_field("out_y", want.y, rsp_out_y);
            check_field("out_red", want.red, rsp_out_red);
            check_field("out_green", want.green, rsp_out_green);
            check_field("out_blue", want.blue, rsp_out_blue);
            check_field("colour_changed", want.colour_changed, rsp_colour_changed);
            check_field("swapped_unblank", want.swapped_unblank, rsp_swapped_unblank);
            n_draws += want.draw_valid;
            n_swaps += want.swapped_unblank;
            n_colour_changes += want.colour_changed;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  expected_beats.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= lpls_pkg::MODE_TICK;
      req_point_index <= '0;
      req_x_coord <= '0;
      req_y_coord <= '0;
      req_red_level <= '0;
      req_green_level <= '0;
      req_blue_level <= '0;
      req_frame_size <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_frame();
      test_backpressure();
      test_random_phase(0, 0, PHASE_ITEMS);
      test_random_phase(64, 0, PHASE_ITEMS);
      test_random_phase(0, 64, PHASE_ITEMS);
      test_random_phase(20, 20, PHASE_ITEMS);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d items: %0d points drawn, %0d swaps, %0d colour changes, %0d errors",
               items_sent, n_draws, n_swaps, n_colour_changes, errors);
      $display("covered an oversized commit, a %0d cycle rsp hold-off and mixed idle/stall",
               HOLD_OFF_LEN);
      if (errors == 0 && expected_beats.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/lpls_pkg.sv
hw/rtl/laser_point_list_scanner_unit.sv
sim/laser_point_list_scanner_unit_tb.sv
